/* design/stbr_pkg.sv */
// Shared types and constants of the sorted table range relocate block.
package stbr_pkg;

   localparam int TableDepthDefault = 64;
   localparam int MaxResults        = 64;
   localparam int AddrW             = 64;
   localparam int IdW               = 64;
   localparam int LenW              = 32;
   localparam int MatchCntW         = $clog2(MaxResults + 1);

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_SURVIVE = 2'd1,
      OP_MOVE    = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FLUSH,
      ST_FULL
   } state_type;

endpackage

/* design/stbr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module stbr_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sorted_table_range_relocate.sv */
// Top level: sorted address table with insert, range relocation and clear.
//
// Usage
//   Input channel (req_*): one item per handshake, accepted when req_valid is
//   high and req_stall low. req_stall is high whenever the sequencer is busy.
//   Result channel (rsp_*): one output register; the receiver holds it with
//   rsp_stall and the block waits for the register to free up before pushing.
//   Load: insertion sort step, walks down from the top of the table moving
//     each larger entry up one slot by a RAM read (INS_RD), then a compare
//     and write (INS_CMP); the new entry is written in INS_PUT, straight away
//     for an empty table. req_stall stays high until that write.
//     A load into a full table returns one item with status 1.
//   Range (surviving or moving): linear scan of all stored entries, each
//     read from the RAM (SCAN_RD), then compared and relocated (SCAN_CMP);
//     a FLUSH state sends the final item carrying last. Up to 64 items are
//     returned in table order; the scan stops once 64 matches are held.
//   Clear: empties the table (entry count to zero), no result.
//   The block takes no new item until it is through with the last; a range
//   scan is bound by the single table RAM read port.
// Reset: entry count and all control state clear; table contents
// are left as they are and never read above the count.
// Receiver stall: the scan freezes on a match until the output register frees.
module sorted_table_range_relocate #(
   parameter int TABLE_DEPTH = stbr_pkg::TableDepthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [stbr_pkg::AddrW-1:0]  req_entry_address,
   input  logic [stbr_pkg::IdW-1:0]    req_entry_tracked_id,
   input  logic [stbr_pkg::AddrW-1:0]  req_range_start,
   input  logic [stbr_pkg::AddrW-1:0]  req_new_start,
   input  logic [stbr_pkg::LenW-1:0]   req_range_length,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_status,
   output logic [stbr_pkg::AddrW-1:0]  rsp_out_address,
   output logic [stbr_pkg::IdW-1:0]    rsp_out_tracked_id,
   output logic                        rsp_last
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int DW = stbr_pkg::AddrW + stbr_pkg::IdW;
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
   localparam logic [stbr_pkg::MatchCntW-1:0] MaxC =
      stbr_pkg::MatchCntW'(stbr_pkg::MaxResults);

   stbr_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic [stbr_pkg::AddrW-1:0]       addr_ff, addr_in;
   logic [stbr_pkg::IdW-1:0]         id_ff, id_in;
   logic [stbr_pkg::AddrW-1:0]       start_ff, start_in;
   logic [stbr_pkg::AddrW-1:0]       dest_ff, dest_in;
   logic [stbr_pkg::LenW-1:0]        len_ff, len_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [stbr_pkg::AddrW-1:0]       pend_addr_ff, pend_addr_in;
   logic [stbr_pkg::IdW-1:0]         pend_id_ff, pend_id_in;
   logic [stbr_pkg::MatchCntW-1:0]   nmatch_ff, nmatch_in;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_status_ff, out_status_in;
   logic [stbr_pkg::AddrW-1:0]       out_addr_ff, out_addr_in;
   logic [stbr_pkg::IdW-1:0]         out_id_ff, out_id_in;
   logic                             out_last_ff, out_last_in;

   logic                             wr_en, rd_en;
   logic [AW-1:0]                    wr_addr, rd_addr;
   logic [DW-1:0]                    wr_data, rd_data;
   logic [stbr_pkg::AddrW-1:0]       rd_entry_addr;
   logic [stbr_pkg::IdW-1:0]         rd_entry_id;
   logic [stbr_pkg::AddrW-1:0]       offset;
   logic                             hit;
   logic                             out_free;
   logic                             accept;
   logic [CW-1:0]                    idx_dec;
   logic [CW-1:0]                    idx_inc;
   stbr_pkg::opcode_type             op;

   stbr_ram #(.Width(DW), .Depth(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry_addr = rd_data[DW-1 -: stbr_pkg::AddrW];
   assign rd_entry_id   = rd_data[stbr_pkg::IdW-1:0];
   // Wrapping range test: offset from start, modulo 2^64, below the length.
   assign offset   = rd_entry_addr - start_ff;
   assign hit      = offset < {{(stbr_pkg::AddrW - stbr_pkg::LenW){1'b0}}, len_ff};
   assign out_free = !out_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign idx_dec  = idx_ff - CW'(1);
   assign idx_inc  = idx_ff + CW'(1);
   assign op       = stbr_pkg::opcode_type'(req_opcode);

   assign req_stall          = (state_ff != stbr_pkg::ST_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_out_address    = out_addr_ff;
   assign rsp_out_tracked_id = out_id_ff;
   assign rsp_last           = out_last_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stbr_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  stbr_pkg::OP_LOAD: begin
                     if (count_ff >= DepthC) begin
                        state_in = stbr_pkg::ST_FULL;
                     end else if (count_ff == '0) begin
                        state_in = stbr_pkg::ST_INS_PUT;
                     end else begin
                        state_in = stbr_pkg::ST_INS_RD;
                     end
                  end
                  stbr_pkg::OP_SURVIVE, stbr_pkg::OP_MOVE: begin
                     if (count_ff != '0) begin
                        state_in = stbr_pkg::ST_SCAN_RD;
                     end
                  end
                  stbr_pkg::OP_CLEAR: state_in = stbr_pkg::ST_IDLE;
                  default:            state_in = stbr_pkg::ST_IDLE;
               endcase
            end
         end
         stbr_pkg::ST_INS_RD:  state_in = stbr_pkg::ST_INS_CMP;
         stbr_pkg::ST_INS_CMP: begin
            if (rd_entry_addr > addr_ff) begin
               state_in = (idx_dec == '0) ? stbr_pkg::ST_INS_PUT : stbr_pkg::ST_INS_RD;
            end else begin
               state_in = stbr_pkg::ST_INS_PUT;
            end
         end
         stbr_pkg::ST_INS_PUT: state_in = stbr_pkg::ST_IDLE;
         stbr_pkg::ST_SCAN_RD: state_in = stbr_pkg::ST_SCAN_CMP;
         stbr_pkg::ST_SCAN_CMP: begin
            if (hit && pend_valid_ff && !out_free) begin
               state_in = stbr_pkg::ST_SCAN_CMP;
            end else if ((hit && nmatch_ff + stbr_pkg::MatchCntW'(1) == MaxC)
                         || idx_inc == count_ff) begin
               state_in = stbr_pkg::ST_FLUSH;
            end else begin
               state_in = stbr_pkg::ST_SCAN_RD;
            end
         end
         stbr_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = stbr_pkg::ST_IDLE;
            end
         end
         stbr_pkg::ST_FULL: begin
            if (out_free) begin
               state_in = stbr_pkg::ST_IDLE;
            end
         end
         default: state_in = stbr_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      addr_in       = addr_ff;
      id_in         = id_ff;
      start_in      = start_ff;
      dest_in       = dest_ff;
      len_in        = len_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_id_in    = pend_id_ff;
      nmatch_in     = nmatch_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_addr_in   = out_addr_ff;
      out_id_in     = out_id_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = {addr_ff, id_ff};
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];

      unique case (state_ff)
         stbr_pkg::ST_IDLE: begin
            if (accept) begin
               addr_in   = req_entry_address;
               id_in     = req_entry_tracked_id;
               start_in  = req_range_start;
               // A surviving range relocates onto itself.
               dest_in   = (op == stbr_pkg::OP_MOVE) ? req_new_start : req_range_start;
               len_in    = req_range_length;
               nmatch_in = '0;
               idx_in    = (op == stbr_pkg::OP_LOAD) ? count_ff : '0;
               if (op == stbr_pkg::OP_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         stbr_pkg::ST_INS_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_dec[AW-1:0];
         end
         stbr_pkg::ST_INS_CMP: begin
            // Larger entries move up one slot; equal ones stay below.
            if (rd_entry_addr > addr_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_dec;
            end
         end
         stbr_pkg::ST_INS_PUT: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
         stbr_pkg::ST_SCAN_RD: begin
            rd_en = 1'b1;
         end
         stbr_pkg::ST_SCAN_CMP: begin
            if (!(hit && pend_valid_ff && !out_free)) begin
               idx_in = idx_inc;
               if (hit) begin
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_status_in = 1'b0;
                     out_addr_in   = pend_addr_ff;
                     out_id_in     = pend_id_ff;
                     out_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_addr_in  = dest_ff + offset;
                  pend_id_in    = rd_entry_id;
                  nmatch_in     = nmatch_ff + stbr_pkg::MatchCntW'(1);
               end
            end
         end
         stbr_pkg::ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = 1'b0;
               out_addr_in   = pend_addr_ff;
               out_id_in     = pend_id_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         stbr_pkg::ST_FULL: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = 1'b1;
               out_addr_in   = addr_ff;
               out_id_in     = id_ff;
               out_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stbr_pkg::ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         nmatch_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         nmatch_ff     <= nmatch_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      addr_ff       <= addr_in;
      id_ff         <= id_in;
      start_ff      <= start_in;
      dest_ff       <= dest_in;
      len_ff        <= len_in;
      pend_addr_ff  <= pend_addr_in;
      pend_id_ff    <= pend_id_in;
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
      out_id_ff     <= out_id_in;
      out_last_ff   <= out_last_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC)
      else $error("entry count above table depth");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == stbr_pkg::ST_IDLE |-> !pend_valid_ff)
      else $error("pending match left behind after a range");

   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      nmatch_ff <= MaxC)
      else $error("match count above result limit");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == stbr_pkg::ST_INS_PUT |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not bump entry count");

endmodule

/* sim/stbr_checker.sv */
// Checker: watches both channels, predicts table behavior, compares results.
`timescale 1ns / 1ps
module stbr_checker #(
   parameter int TABLE_DEPTH = stbr_pkg::TableDepthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [stbr_pkg::AddrW-1:0] req_entry_address,
   input  logic [stbr_pkg::IdW-1:0]   req_entry_tracked_id,
   input  logic [stbr_pkg::AddrW-1:0] req_range_start,
   input  logic [stbr_pkg::AddrW-1:0] req_new_start,
   input  logic [stbr_pkg::LenW-1:0]  req_range_length,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_status,
   input  logic [stbr_pkg::AddrW-1:0] rsp_out_address,
   input  logic [stbr_pkg::IdW-1:0]   rsp_out_tracked_id,
   input  logic                       rsp_last,
   output int                         error_count,
   output int                         pending_count
);

   typedef struct packed {
      logic                       status;
      logic [stbr_pkg::AddrW-1:0] address;
      logic [stbr_pkg::IdW-1:0]   tracked_id;
      logic                       last;
   } match_item_type;

   match_item_type             expected_matches[$];
   logic [stbr_pkg::AddrW-1:0] table_addr[TABLE_DEPTH];
   logic [stbr_pkg::IdW-1:0]   table_id[TABLE_DEPTH];
   int                         table_fill;

   assign pending_count = expected_matches.size();

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic insert_entry(input logic [stbr_pkg::AddrW-1:0] a,
                               input logic [stbr_pkg::IdW-1:0] id);
      int pos;
      pos = 0;
      while (pos < table_fill && table_addr[pos] <= a) pos++;
      for (int k = table_fill; k > pos; k--) begin
         table_addr[k] = table_addr[k-1];
         table_id[k]   = table_id[k-1];
      end
      table_addr[pos] = a;
      table_id[pos]   = id;
      table_fill++;
   endtask

   task automatic predict_range(input logic [stbr_pkg::AddrW-1:0] start,
                                input logic [stbr_pkg::AddrW-1:0] dest,
                                input logic [stbr_pkg::LenW-1:0] len);
      logic [stbr_pkg::AddrW-1:0] off;
      int                         n;
      match_item_type             m;
      n = 0;
      for (int k = 0; k < table_fill; k++) begin
         off = table_addr[k] - start;
         if (off < {32'd0, len} && n < stbr_pkg::MaxResults) begin
            m = '{1'b0, dest + off, table_id[k], 1'b0};
            expected_matches.push_back(m);
            n++;
         end
      end
      // mark final result of this item
      if (n > 0) expected_matches[$].last = 1'b1;
   endtask

   always @(posedge clock) begin
      match_item_type e;
      if (reset) begin
         table_fill  = 0;
         error_count = 0;
         expected_matches.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               e = expected_matches.pop_front();
               if (rsp_status !== e.status)
                  report_mismatch($sformatf("status %0b exp %0b", rsp_status, e.status));
               if (rsp_out_address !== e.address)
                  report_mismatch($sformatf("address %h exp %h", rsp_out_address, e.address));
               if (rsp_out_tracked_id !== e.tracked_id)
                  report_mismatch($sformatf("id %h exp %h", rsp_out_tracked_id, e.tracked_id));
               if (rsp_last !== e.last)
                  report_mismatch($sformatf("last %0b exp %0b", rsp_last, e.last));
            end
         end
         if (req_valid && !req_stall) begin
            case (stbr_pkg::opcode_type'(req_opcode))
               stbr_pkg::OP_LOAD: begin
                  if (table_fill >= TABLE_DEPTH)
                     expected_matches.push_back('{1'b1, req_entry_address,
                                                  req_entry_tracked_id, 1'b1});
                  else
                     insert_entry(req_entry_address, req_entry_tracked_id);
               end
               stbr_pkg::OP_SURVIVE:
                  predict_range(req_range_start, req_range_start, req_range_length);
               stbr_pkg::OP_MOVE:
                  predict_range(req_range_start, req_new_start, req_range_length);
               default: table_fill = 0;
            endcase
         end
      end
   end

endmodule

/* sim/tb_sorted_table_range_relocate.sv */
// Testbench top: stimulus, idling phases, watchdog and verdict.
`timescale 1ns / 1ps
module tb_sorted_table_range_relocate;

   localparam int WatchdogLimit = 20000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_opcode = stbr_pkg::OP_CLEAR;
   logic [stbr_pkg::AddrW-1:0] req_entry_address = '0;
   logic [stbr_pkg::IdW-1:0]   req_entry_tracked_id = '0;
   logic [stbr_pkg::AddrW-1:0] req_range_start = '0;
   logic [stbr_pkg::AddrW-1:0] req_new_start = '0;
   logic [stbr_pkg::LenW-1:0]  req_range_length = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_status;
   logic [stbr_pkg::AddrW-1:0] rsp_out_address;
   logic [stbr_pkg::IdW-1:0]   rsp_out_tracked_id;
   logic                       rsp_last;
   int                         error_count;
   int                         pending_count;
   int                         sender_idle_pct = 0;
   int                         receiver_stall_pct = 0;
   int                         quiet_cycles = 0;
   logic [stbr_pkg::AddrW-1:0] addr_base = '0;   // keeps random addresses clustered

   always #5 clock = ~clock;

   sorted_table_range_relocate #(.TABLE_DEPTH(64)) DUT (.*);

   stbr_checker #(.TABLE_DEPTH(64)) u_checker (.*);

   // receiver stall, re-drawn every cycle
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("tb_sorted_table_range_relocate: done, errors");
         $finish;
      end
   end

   // drive one item and wait for its handshake; idle gaps come first
   task automatic send_item(input stbr_pkg::opcode_type op,
                            input logic [stbr_pkg::AddrW-1:0] ea,
                            input logic [stbr_pkg::IdW-1:0] eid,
                            input logic [stbr_pkg::AddrW-1:0] rs,
                            input logic [stbr_pkg::AddrW-1:0] ns,
                            input logic [stbr_pkg::LenW-1:0] len);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_opcode           <= op;
      req_entry_address    <= ea;
      req_entry_tracked_id <= eid;
      req_range_start      <= rs;
      req_new_start        <= ns;
      req_range_length     <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic random_item();
      int          pick;
      logic [63:0] a;
      pick = $urandom_range(99);
      a = addr_base + 64'($urandom_range(255));
      if (pick < 55)
         send_item(stbr_pkg::OP_LOAD, ($urandom_range(9) == 0) ? rand64() : a, rand64(),
                   rand64(), rand64(), $urandom());
      else if (pick < 75)
         send_item(stbr_pkg::OP_SURVIVE, rand64(), rand64(), a, rand64(),
                   ($urandom_range(9) == 0) ? $urandom() : $urandom_range(300));
      else if (pick < 96)
         send_item(stbr_pkg::OP_MOVE, rand64(), rand64(),
                   ($urandom_range(9) == 0) ? rand64() : a, rand64(),
                   ($urandom_range(9) == 0) ? $urandom() : $urandom_range(300));
      else
         send_item(stbr_pkg::OP_CLEAR, rand64(), rand64(), rand64(), rand64(), $urandom());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, duplicates, wrap, final address, empty range
      send_item(stbr_pkg::OP_SURVIVE, '0, '0, '0, '0, '1);              // empty table
      send_item(stbr_pkg::OP_LOAD, '0, '1, '0, '0, '0);
      send_item(stbr_pkg::OP_LOAD, '1, '0, '1, '1, '1);
      send_item(stbr_pkg::OP_LOAD, 64'h100, 64'hA, '0, '0, '0);
      send_item(stbr_pkg::OP_LOAD, 64'h100, 64'hB, '0, '0, '0);         // duplicate after
      send_item(stbr_pkg::OP_LOAD, 64'h10F, 64'hC, '0, '0, '0);
      send_item(stbr_pkg::OP_SURVIVE, '0, '0, 64'h100, '0, 32'h10);     // final address
      send_item(stbr_pkg::OP_MOVE, '0, '0, 64'h100, '1, 32'h10);        // relocation wraps
      send_item(stbr_pkg::OP_MOVE, '0, '0, 64'h100, 64'h5000, 32'h0);   // zero length
      send_item(stbr_pkg::OP_MOVE, '0, '0, 64'h200, 64'h5000, 32'h8);   // no match
      send_item(stbr_pkg::OP_MOVE, '0, '0, '1, 64'h77, 32'h2);          // range wraps
      send_item(stbr_pkg::OP_SURVIVE, '0, '0, '0, '0, '1);
      send_item(stbr_pkg::OP_CLEAR, '1, '1, '1, '1, '1);
      send_item(stbr_pkg::OP_SURVIVE, '0, '0, '0, '0, '1);
      for (int k = 0; k < 66; k++)                                      // fill, overflow
         send_item(stbr_pkg::OP_LOAD, 64'(k * 3), 64'(k), '0, '0, '0);
      send_item(stbr_pkg::OP_MOVE, '0, '0, '0, 64'hFFFF_0000, '1);      // 64 matches
      drain();                                                          // wait out results
      send_item(stbr_pkg::OP_CLEAR, '0, '0, '0, '0, '0);

      // random phases of idling
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = (phase == 1) ? 71 : (phase == 3) ? 35 : 0;
         receiver_stall_pct = (phase == 2) ? 71 : (phase == 3) ? 35 : 0;
         addr_base = rand64();
         for (int n = 0; n < 80; n++) random_item();
         drain();
      end

      if (error_count == 0)
         $display("tb_sorted_table_range_relocate: done, clean");
      else
         $display("tb_sorted_table_range_relocate: done, errors");
      $finish;
   end

endmodule

/* sorted_table_range_relocate.f */
design/stbr_pkg.sv
design/stbr_ram.sv
design/sorted_table_range_relocate.sv
sim/stbr_checker.sv
sim/tb_sorted_table_range_relocate.sv
